[hw/rtl/msmq_pkg.sv]
package msmq_pkg;

  localparam int NUM_MOTORS_DEF  = 16;
  localparam int QUEUE_DEPTH_DEF = 8;

  localparam int TYPE_W  = 2;
  localparam int MOTOR_W = 4;
  localparam int POS_W   = 32;
  localparam int INTV_W  = 24;
  localparam int TIME_W  = 32;
  localparam int MASK_W  = 16;
  localparam int ACT_W   = 5;

  localparam logic [TYPE_W-1:0] REQ_ENQ  = 2'd0;
  localparam logic [TYPE_W-1:0] REQ_TICK = 2'd1;
  localparam logic [TYPE_W-1:0] REQ_READ = 2'd2;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_ENQ,
    ST_TICK_RD,
    ST_TICK_EVAL,
    ST_TICK_EXEC,
    ST_FIN
  } ctrl_state_t;

  typedef struct packed {
    logic load_req;
    logic enq;
    logic rd_issue;
    logic eval;
    logic exec;
    logic skip;
    logic out_load;
  } dp_cmd_t;

  typedef struct packed {
    logic [TYPE_W-1:0] new_type;
    logic              tick_end;
    logic              head_busy;
    logic              out_free;
  } dp_sts_t;

  typedef struct packed {
    logic [POS_W-1:0]  goal;
    logic [INTV_W-1:0] intv;
    logic [TIME_W-1:0] last;
  } move_t;

endpackage

[hw/rtl/msmq_ifs.sv]
interface msmq_req_if import msmq_pkg::*; ();
  logic                     valid;
  logic                     ready;
  logic [TYPE_W-1:0]        req_type;
  logic [MOTOR_W-1:0]       motor;
  logic signed [POS_W-1:0]  goal_position;
  logic [INTV_W-1:0]        step_interval;
  logic [TIME_W-1:0]        now_usec;

  modport source (output valid, req_type, motor, goal_position, step_interval, now_usec,
                  input ready);
  modport sink (input valid, req_type, motor, goal_position, step_interval, now_usec,
                output ready);
endinterface

interface msmq_rsp_if import msmq_pkg::*; ();
  logic                     valid;
  logic                     ready;
  logic                     accepted;
  logic [MASK_W-1:0]        step_mask;
  logic [MASK_W-1:0]        backward_mask;
  logic [MASK_W-1:0]        done_mask;
  logic [MASK_W-1:0]        idle_mask;
  logic signed [POS_W-1:0]  position;

  modport source (output valid, accepted, step_mask, backward_mask, done_mask, idle_mask,
                  position, input ready);
  modport sink (input valid, accepted, step_mask, backward_mask, done_mask, idle_mask,
                position, output ready);
endinterface

[hw/rtl/msmq_ram.sv]
module msmq_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16,
  localparam int AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic             re,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

[hw/rtl/msmq_ctrl.sv]
module msmq_ctrl import msmq_pkg::*; (
  input  logic    clk,
  input  logic    rst,
  input  logic    req_valid,
  output logic    req_ready,
  input  dp_sts_t sts,
  output dp_cmd_t cmd
);

  ctrl_state_t state, state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    cmd        = '0;
    req_ready  = 1'b0;
    unique case (state)
      ST_IDLE: begin
        req_ready = 1'b1;
        if (req_valid) begin
          cmd.load_req = 1'b1;
          unique case (sts.new_type)
            REQ_ENQ:  state_next = ST_ENQ;
            REQ_TICK: state_next = ST_TICK_RD;
            default:  state_next = ST_FIN;
          endcase
        end
      end
      ST_ENQ: begin
        cmd.enq    = 1'b1;
        state_next = ST_FIN;
      end
      ST_TICK_RD: begin
        if (sts.tick_end) begin
          state_next = ST_FIN;
        end else if (sts.head_busy) begin
          cmd.rd_issue = 1'b1;
          state_next   = ST_TICK_EVAL;
        end else begin
          cmd.skip = 1'b1;
        end
      end
      ST_TICK_EVAL: begin
        cmd.eval   = 1'b1;
        state_next = ST_TICK_EXEC;
      end
      ST_TICK_EXEC: begin
        cmd.exec   = 1'b1;
        state_next = ST_TICK_RD;
      end
      ST_FIN: begin
        // hold the result until the output register is free
        if (sts.out_free) begin
          cmd.out_load = 1'b1;
          state_next   = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

endmodule

[hw/rtl/msmq_dp.sv]
module msmq_dp import msmq_pkg::*; #(
  parameter int NUM_MOTORS  = NUM_MOTORS_DEF,
  parameter int QUEUE_DEPTH = QUEUE_DEPTH_DEF
) (
  input  logic                    clk,
  input  logic                    rst,
  input  dp_cmd_t                 cmd,
  output dp_sts_t                 sts,
  input  logic [TYPE_W-1:0]       req_type,
  input  logic [MOTOR_W-1:0]      motor,
  input  logic signed [POS_W-1:0] goal_position,
  input  logic [INTV_W-1:0]       step_interval,
  input  logic [TIME_W-1:0]       now_usec,
  input  logic                    cfg_we,
  input  logic [ACT_W-1:0]        cfg_data,
  input  logic                    rsp_ready,
  output logic                    rsp_valid,
  output logic                    accepted,
  output logic [MASK_W-1:0]       step_mask,
  output logic [MASK_W-1:0]       backward_mask,
  output logic [MASK_W-1:0]       done_mask,
  output logic [MASK_W-1:0]       idle_mask,
  output logic signed [POS_W-1:0] position
);

  localparam int SLOTS = NUM_MOTORS * QUEUE_DEPTH;
  localparam int AW    = (SLOTS > 1) ? $clog2(SLOTS) : 1;
  localparam int HW    = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int CW    = $clog2(QUEUE_DEPTH + 1);
  localparam int TW    = CW + 1;
  localparam int XW    = (NUM_MOTORS > 1) ? $clog2(NUM_MOTORS) : 1;

  logic [ACT_W-1:0]   act;
  logic [ACT_W-1:0]   used;
  logic [ACT_W-1:0]   cnt;

  logic [TYPE_W-1:0]  r_type;
  logic [MOTOR_W-1:0] r_motor;
  logic [POS_W-1:0]   r_goal;
  logic [INTV_W-1:0]  r_intv;
  logic [TIME_W-1:0]  r_now;

  logic [POS_W-1:0]   pos_q   [NUM_MOTORS];
  logic [HW-1:0]      head_q  [NUM_MOTORS];
  logic [CW-1:0]      count_q [NUM_MOTORS];

  logic               acc_accepted;
  logic [MASK_W-1:0]  acc_step, acc_back, acc_done;
  logic               f_goal, f_due, f_fwd;

  logic [XW-1:0]      cur;
  logic [POS_W-1:0]   cur_pos;
  logic [HW-1:0]      cur_head, head_inc;
  logic [CW-1:0]      cur_count;
  logic [TW-1:0]      tail_sum, tail;
  logic [AW-1:0]      base, enq_addr, head_addr;
  logic               enq_ok;
  logic               motor_exists;
  logic [MASK_W-1:0]  cur_bit;
  logic [MASK_W-1:0]  idle_now;

  logic               ram_we;
  logic [AW-1:0]      ram_waddr;
  move_t              ram_wdata, rd;
  logic [$bits(move_t)-1:0] ram_rdata;

  assign used = (act > ACT_W'(NUM_MOTORS)) ? ACT_W'(NUM_MOTORS) : act;

  // tick walks the motor counter; enqueue and read use the requested motor
  assign cur       = (r_type == REQ_TICK) ? cnt[XW-1:0] : r_motor[XW-1:0];
  assign cur_pos   = pos_q[cur];
  assign cur_head  = head_q[cur];
  assign cur_count = count_q[cur];
  assign cur_bit   = MASK_W'(1) << cur;

  assign motor_exists = {1'b0, r_motor} < ACT_W'(NUM_MOTORS);
  assign enq_ok = ({1'b0, r_motor} < used) && (cur_count < CW'(QUEUE_DEPTH));

  // head + count stays below twice the depth, so one subtract wraps it
  assign tail_sum = TW'(cur_head) + TW'(cur_count);
  assign tail     = (tail_sum >= TW'(QUEUE_DEPTH)) ? tail_sum - TW'(QUEUE_DEPTH) : tail_sum;
  assign head_inc = (cur_head == HW'(QUEUE_DEPTH - 1)) ? '0 : cur_head + HW'(1);

  assign base      = AW'(cur) * AW'(QUEUE_DEPTH);
  assign enq_addr  = base + AW'(tail);
  assign head_addr = base + AW'(cur_head);

  assign rd = move_t'(ram_rdata);

  assign ram_we    = (cmd.enq && enq_ok) || (cmd.exec && !f_goal && f_due);
  assign ram_waddr = cmd.enq ? enq_addr : head_addr;
  always_comb begin
    if (cmd.enq) begin
      ram_wdata = '{goal: r_goal, intv: r_intv, last: r_now};
    end else begin
      ram_wdata = '{goal: rd.goal, intv: rd.intv, last: r_now};
    end
  end

  msmq_ram #(
    .WIDTH ($bits(move_t)),
    .DEPTH (SLOTS)
  ) u_move_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .re    (cmd.rd_issue),
    .raddr (head_addr),
    .rdata (ram_rdata)
  );

  always_comb begin
    idle_now = '0;
    for (int i = 0; i < NUM_MOTORS; i++) begin
      idle_now[i] = (count_q[i] == '0);
    end
  end

  assign sts.new_type  = req_type;
  assign sts.tick_end  = (cnt >= used);
  assign sts.head_busy = (cur_count != '0);
  assign sts.out_free  = !rsp_valid || rsp_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      act       <= '0;
      cnt       <= '0;
      rsp_valid <= 1'b0;
      for (int i = 0; i < NUM_MOTORS; i++) begin
        pos_q[i]   <= '0;
        head_q[i]  <= '0;
        count_q[i] <= '0;
      end
    end else begin
      if (cfg_we) begin
        act <= cfg_data;
      end
      if (cmd.load_req) begin
        cnt <= '0;
      end else if (cmd.skip || cmd.exec) begin
        cnt <= cnt + ACT_W'(1);
      end
      if (cmd.enq && enq_ok) begin
        count_q[cur] <= cur_count + CW'(1);
      end
      if (cmd.exec) begin
        if (f_goal) begin
          head_q[cur]  <= head_inc;
          count_q[cur] <= cur_count - CW'(1);
        end else if (f_due) begin
          pos_q[cur] <= f_fwd ? cur_pos + POS_W'(1) : cur_pos - POS_W'(1);
        end
      end
      if (cmd.out_load) begin
        rsp_valid <= 1'b1;
      end else if (rsp_ready) begin
        rsp_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load_req) begin
      r_type       <= req_type;
      r_motor      <= motor;
      r_goal       <= goal_position;
      r_intv       <= step_interval;
      r_now        <= now_usec;
      acc_accepted <= 1'b0;
      acc_step     <= '0;
      acc_back     <= '0;
      acc_done     <= '0;
    end
    if (cmd.enq) begin
      acc_accepted <= enq_ok;
    end
    if (cmd.eval) begin
      f_goal <= (cur_pos == rd.goal);
      f_due  <= (r_now - rd.last) > TIME_W'(rd.intv);
      f_fwd  <= $signed(rd.goal) > $signed(cur_pos);
    end
    if (cmd.exec) begin
      if (f_goal) begin
        acc_done <= acc_done | cur_bit;
      end else if (f_due) begin
        acc_step <= acc_step | cur_bit;
        if (!f_fwd) begin
          acc_back <= acc_back | cur_bit;
        end
      end
    end
    if (cmd.out_load) begin
      accepted      <= acc_accepted;
      step_mask     <= acc_step;
      backward_mask <= acc_back;
      done_mask     <= acc_done;
      idle_mask     <= idle_now;
      position      <= (r_type == REQ_READ && motor_exists) ? cur_pos : '0;
    end
  end

endmodule

[hw/rtl/multi_stepper_move_queue.sv]
// channel | dir | handshake     | word
// req     | in  | valid / ready | req_type, motor, goal_position, step_interval, now_usec
// rsp     | out | valid / ready | accepted, step/backward/done/idle masks, position
// cfg     | in  | cfg_we        | cfg_data = active_motors
//
// A tick visits each active motor in turn: a motor with an empty queue is skipped,
// and one with a queued move goes through read, evaluate and update, in that order,
// as the RAM read and the step decision are both registered.
// rst clears positions, queue pointers and active_motors; move RAM is not cleared.
// A new word is taken while the last result waits in the output register; its result
// is held back until that register is free.
module multi_stepper_move_queue import msmq_pkg::*; #(
  parameter int NUM_MOTORS  = NUM_MOTORS_DEF,
  parameter int QUEUE_DEPTH = QUEUE_DEPTH_DEF
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              cfg_we,
  input  logic [ACT_W-1:0]  cfg_data,
  msmq_req_if.sink          req,
  msmq_rsp_if.source        rsp
);

  dp_cmd_t cmd;
  dp_sts_t sts;

  msmq_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .req_valid (req.valid),
    .req_ready (req.ready),
    .sts       (sts),
    .cmd       (cmd)
  );

  msmq_dp #(
    .NUM_MOTORS  (NUM_MOTORS),
    .QUEUE_DEPTH (QUEUE_DEPTH)
  ) u_dp (
    .clk           (clk),
    .rst           (rst),
    .cmd           (cmd),
    .sts           (sts),
    .req_type      (req.req_type),
    .motor         (req.motor),
    .goal_position (req.goal_position),
    .step_interval (req.step_interval),
    .now_usec      (req.now_usec),
    .cfg_we        (cfg_we),
    .cfg_data      (cfg_data),
    .rsp_ready     (rsp.ready),
    .rsp_valid     (rsp.valid),
    .accepted      (rsp.accepted),
    .step_mask     (rsp.step_mask),
    .backward_mask (rsp.backward_mask),
    .done_mask     (rsp.done_mask),
    .idle_mask     (rsp.idle_mask),
    .position      (rsp.position)
  );

`ifndef NO_ASSERTIONS
  a_step_done_apart: assert property (@(posedge clk) disable iff (rst)
    rsp.valid |-> (rsp.step_mask & rsp.done_mask) == '0)
    else $error("motor both stepped and retired a move in one tick");

  a_back_in_step: assert property (@(posedge clk) disable iff (rst)
    rsp.valid |-> (rsp.backward_mask & ~rsp.step_mask) == '0)
    else $error("backward bit set for a motor that did not step");

  a_enq_clean: assert property (@(posedge clk) disable iff (rst)
    rsp.valid && rsp.accepted |->
      rsp.step_mask == '0 && rsp.done_mask == '0 && rsp.position == '0)
    else $error("accepted enqueue carries tick or read fields");

  a_busy_after_accept: assert property (@(posedge clk) disable iff (rst)
    req.valid && req.ready |=> !req.ready)
    else $error("request taken while the previous one is still in work");
`endif

endmodule
